>>> hw/rtl/rht_pkg.sv
// rht_pkg: request and result payload types, request and status codes and
// sequencer states for the refcounted handle table
// no dependencies
`default_nettype none

package rht_pkg;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_CLOSE  = 2'd2,
    REQ_DUP    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HANDLE = 3'd1,
    ST_FULL       = 3'd2,
    ST_NULL_OBJ   = 3'd3,
    ST_SATURATED  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_SEARCH,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] handle_in;
    logic [63:0] object_tag;
    logic [7:0]  object_kind;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  handle_out;
    logic [63:0] object_out;
    logic [7:0]  kind_out;
    logic [15:0] refs_out;
    logic        slot_freed;
    logic [8:0]  live_count;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/rht_ram.sv
// rht_ram: generic single-port ram, one write or read per cycle,
// registered read data; no dependencies
`default_nettype none

module rht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/rht_scan.sv
// rht_scan: free-slot scan window, checks up to eight slots per cycle
// from a rotating base and returns the first free one; no dependencies
`default_nettype none

module rht_scan #(
  parameter int unsigned SLOTS = 256,
  localparam int unsigned IW = $clog2(SLOTS)
) (
  input  wire logic [SLOTS-1:0] used_i,
  input  wire logic [IW-1:0]    base_i,
  output logic                  found_o,
  output logic      [IW-1:0]    slot_o,
  output logic      [IW-1:0]    next_o
);

  localparam int unsigned LANES = (SLOTS < 8) ? SLOTS : 8;

  logic [IW:0] pos [LANES];
  logic [IW:0] nsum;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      pos[k] = {1'b0, base_i} + (IW+1)'(k);
      if (pos[k] >= (IW+1)'(SLOTS)) begin
        pos[k] = pos[k] - (IW+1)'(SLOTS);
      end
    end
  end

  // lowest lane wins
  always_comb begin
    found_o = 1'b0;
    slot_o  = '0;
    for (int k = LANES - 1; k >= 0; k--) begin
      if (!used_i[pos[k][IW-1:0]]) begin
        found_o = 1'b1;
        slot_o  = pos[k][IW-1:0];
      end
    end
  end

  always_comb begin
    nsum = {1'b0, base_i} + (IW+1)'(LANES);
    if (nsum >= (IW+1)'(SLOTS)) begin
      nsum = nsum - (IW+1)'(SLOTS);
    end
    next_o = nsum[IW-1:0];
  end

endmodule

`default_nettype wire

>>> hw/rtl/refcounted_handle_table_unit.sv
// refcounted_handle_table_unit: top level, request sequencer, in-use bits,
// rover and live count; uses rht_pkg, rht_scan and rht_ram
//
// usage:
//   request channel req_valid_i / req_stall_o / req_i carries create, lookup,
//   close and duplicate requests; result channel res_valid_o / res_stall_i /
//   res_o returns exactly one result per request, in order.
//   a request is taken only while the sequencer is idle; req_stall_o is high
//   for the whole time a request is being served.
//   lookup, close, duplicate: accept, handle check with the slot read, then the
//   result is formed from the read data, and close and a duplicate that is not
//   saturated write the slot back; a rejected request goes from the check
//   straight to the result. create: null-object and full-table check, then
//   the free-slot scan walks the in-use bits eight slots a cycle from the rover
//   until it finds a free slot, which a table that is not full always holds.
//   the result sits in an output register; a stalled result holds, and the
//   block can take and finish the next request into its result holding
//   register meanwhile, waiting there until the output register frees.
//   reset clears the in-use bits, live count and rover (slot 1) at once;
//   slot ram contents are only used for in-use slots, so no clearing pass.
`default_nettype none

module refcounted_handle_table_unit #(
  parameter int unsigned TABLE_SLOTS = 256,
  parameter int unsigned REF_BITS    = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_stall_o,
  input  wire rht_pkg::req_t req_i,
  output logic               res_valid_o,
  input  wire logic          res_stall_i,
  output rht_pkg::res_t      res_o
);

  import rht_pkg::*;

  localparam int unsigned IDX_W   = $clog2(TABLE_SLOTS);
  localparam int unsigned CNT_W   = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned ENTRY_W = 64 + 8 + REF_BITS;

  state_e                 state_q, state_d;
  req_t                   req_q, req_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [IDX_W-1:0]       ptr_q, ptr_d;
  logic [IDX_W-1:0]       rover_q, rover_d;
  logic [TABLE_SLOTS-1:0] used_q, used_d;
  logic [CNT_W-1:0]       live_q, live_d;
  res_t                   res_q, res_d;
  res_t                   out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_addr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [REF_BITS-1:0]    rd_refs;
  logic [7:0]             rd_kind;
  logic [63:0]            rd_obj;
  logic [REF_BITS-1:0]    dec_refs;

  logic                   is_create;
  logic                   null_obj;
  logic                   tbl_full;
  logic                   h_ok;
  logic [IDX_W-1:0]       hidx;
  logic                   hit;
  logic                   out_free;

  logic                   scan_found;
  logic [IDX_W-1:0]       scan_slot;
  logic [IDX_W-1:0]       scan_next;
  logic [IDX_W:0]         rover_sum;

  function automatic res_t mk_res(input logic [2:0] st, input logic [31:0] h,
                                  input logic [63:0] obj, input logic [7:0] kd,
                                  input logic [31:0] rf, input logic fr,
                                  input logic [31:0] lv);
    res_t r;
    r.status     = st;
    r.handle_out = h[8:0];
    r.object_out = obj;
    r.kind_out   = kd;
    r.refs_out   = rf[15:0];
    r.slot_freed = fr;
    r.live_count = lv[8:0];
    return r;
  endfunction

  rht_scan #(
    .SLOTS (TABLE_SLOTS)
  ) u_scan (
    .used_i  (used_q),
    .base_i  (ptr_q),
    .found_o (scan_found),
    .slot_o  (scan_slot),
    .next_o  (scan_next)
  );

  rht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign rd_refs  = ram_rdata[REF_BITS-1:0];
  assign rd_kind  = ram_rdata[REF_BITS+7:REF_BITS];
  assign rd_obj   = ram_rdata[ENTRY_W-1:REF_BITS+8];
  assign dec_refs = (rd_refs == '0) ? '0 : rd_refs - REF_BITS'(1);

  assign is_create = (req_q.req_type == REQ_CREATE);
  assign null_obj  = (req_q.object_tag == 64'd0);
  assign tbl_full  = (live_q == CNT_W'(TABLE_SLOTS));
  assign h_ok      = (req_q.handle_in != 16'd0) &&
                     (32'(req_q.handle_in) <= 32'(TABLE_SLOTS));
  assign hidx      = IDX_W'(req_q.handle_in - 16'd1);
  assign hit       = h_ok && used_q[hidx];
  assign out_free  = !out_valid_q || !res_stall_i;
  assign rover_sum = {1'b0, scan_slot} + (IDX_W+1)'(1);

  assign req_stall_o = (state_q != S_IDLE);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (is_create) begin
          state_d = (null_obj || tbl_full) ? S_DONE : S_SEARCH;
        end else begin
          state_d = hit ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        state_d = S_DONE;
      end
      S_SEARCH: begin
        if (scan_found) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_d       = req_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    rover_d     = rover_q;
    used_d      = used_q;
    live_d      = live_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && res_stall_i;
    ram_we      = 1'b0;
    ram_addr    = hidx;
    ram_wdata   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d = req_i;
        end
      end
      S_CHECK: begin
        idx_d = hidx;
        ptr_d = rover_q;
        if (is_create) begin
          if (null_obj) begin
            res_d = mk_res(ST_NULL_OBJ, 32'd0, 64'd0, 8'd0, 32'd0, 1'b0, 32'(live_q));
          end else if (tbl_full) begin
            res_d = mk_res(ST_FULL, 32'd0, 64'd0, 8'd0, 32'd0, 1'b0, 32'(live_q));
          end
        end else if (!hit) begin
          res_d = mk_res(ST_BAD_HANDLE, 32'd0, 64'd0, 8'd0, 32'd0, 1'b0, 32'(live_q));
        end
      end
      S_READ: begin
        ram_addr = idx_q;
        case (req_q.req_type)
          REQ_LOOKUP: begin
            res_d = mk_res(ST_OK, 32'(req_q.handle_in), rd_obj, rd_kind,
                           32'(rd_refs), 1'b0, 32'(live_q));
          end
          REQ_CLOSE: begin
            ram_we = 1'b1;
            if (dec_refs == '0) begin
              ram_wdata     = '0;
              used_d[idx_q] = 1'b0;
              live_d        = live_q - CNT_W'(1);
              res_d = mk_res(ST_OK, 32'(req_q.handle_in), 64'd0, 8'd0, 32'd0, 1'b1,
                             32'(live_q - CNT_W'(1)));
            end else begin
              ram_wdata = {rd_obj, rd_kind, dec_refs};
              res_d = mk_res(ST_OK, 32'(req_q.handle_in), 64'd0, 8'd0,
                             32'(dec_refs), 1'b0, 32'(live_q));
            end
          end
          default: begin
            if (rd_refs == {REF_BITS{1'b1}}) begin
              res_d = mk_res(ST_SATURATED, 32'd0, 64'd0, 8'd0, 32'(rd_refs), 1'b0,
                             32'(live_q));
            end else begin
              ram_we    = 1'b1;
              ram_wdata = {rd_obj, rd_kind, rd_refs + REF_BITS'(1)};
              res_d = mk_res(ST_OK, 32'(req_q.handle_in), 64'd0, 8'd0,
                             32'(rd_refs + REF_BITS'(1)), 1'b0, 32'(live_q));
            end
          end
        endcase
      end
      S_SEARCH: begin
        ram_addr = scan_slot;
        if (scan_found) begin
          ram_we            = 1'b1;
          ram_wdata         = {req_q.object_tag, req_q.object_kind, REF_BITS'(1)};
          used_d[scan_slot] = 1'b1;
          live_d            = live_q + CNT_W'(1);
          rover_d = (rover_sum >= (IDX_W+1)'(TABLE_SLOTS)) ? '0 : rover_sum[IDX_W-1:0];
          res_d = mk_res(ST_OK, 32'(scan_slot) + 32'd1, 64'd0, 8'd0, 32'd1, 1'b0,
                         32'(live_q + CNT_W'(1)));
        end else begin
          ptr_d = scan_next;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      live_q      <= '0;
      rover_q     <= IDX_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      live_q      <= live_d;
      rover_q     <= rover_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    idx_q <= idx_d;
    ptr_q <= ptr_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  a_live_matches_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == 32'(live_q))
    else $error("live count differs from in-use bits");

  a_live_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(live_q) <= 32'(TABLE_SLOTS))
    else $error("live count above table size");

  a_fail_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status != ST_OK) |-> (out_q.handle_out == 9'd0))
    else $error("failed request returned a handle");

  a_freed_zero_refs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.slot_freed |->
      (out_q.refs_out == 16'd0) && (out_q.status == ST_OK))
    else $error("freed slot with nonzero count");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) && !scan_found |=> (state_q == S_SEARCH) && req_stall_o)
    else $error("scan left without a free slot");

endmodule

`default_nettype wire
